/* rtl/assert_macros.svh */
// Assertion macros used by the checker file lkv_checker.sv.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lkv_pkg.sv */
// Package for the LRU key-value cache: payload structs, control structs
// and fixed constants. No dependencies.
`default_nettype none

package lkv_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture item, rewind address
    logic issue;   // read one entry, advance address
    logic upd;     // issued read belongs to the rank update pass
    logic decide;  // resolve the scan, write key/value on a put, load result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;    // address is at the last entry
    logic found;   // scan found the key
    logic is_put;  // captured item is a put
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache.
// Uses lkv_pkg, lkv_ctrl, lkv_datapath (which holds the lkv_ram instances).
//
//  channel   dir  handshake                        payload
//  --------  ---  -------------------------------  -------------------------
//  command   in   start & !busy                    item_i   (func/key/value)
//  result    out  result_strobe_o, one cycle       result_o (hit/read_value/
//                                                            evicted/evicted_key)
//  config    in   cfg_valid_i & cfg_ready_o        cfg_data_i (capacity)
//
//  One item at a time. An accepted item runs the search pass (registered
//  reads), the decision, the rank pass and the result cycle. A get miss
//  skips the rank pass. busy falls after the result.
//  Reset clears valid bits, count and state at once; no clearing sweep.
//  The receiver cannot stall. Capacity writes are always taken; make them idle.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  lkv_pkg::item_t            item_i,
  // result channel
  output logic                      result_strobe_o,
  output lkv_pkg::result_t          result_o,
  // configuration channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i
);

  import lkv_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     cfg_we;

  // config register is a plain flop, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  lkv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .strobe_o (result_strobe_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // search, decide and rank update all live here; the controller
  // only sequences the passes
  lkv_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

/* rtl/lkv_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/lkv_datapath.sv */
// Datapath of the LRU cache: key, value and rank RAMs, valid bits,
// occupancy count, capacity register and scan/update logic. Uses lkv_pkg, lkv_ram.
`default_nettype none

module lkv_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkv_pkg::ctl_cmd_t          cmd_i,
  output lkv_pkg::dp_sts_t           sts_o,
  input  logic                       cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data_i,
  input  lkv_pkg::item_t             item_i,
  output lkv_pkg::result_t           result_o
);

  import lkv_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [MW-1:0] ENTRIES_M = MW'(ENTRIES);

  item_t              item_q;
  logic [CAP_W-1:0]   cap_q;
  logic [CW-1:0]      cnt_q;
  logic [ENTRIES-1:0] valid_q;
  logic [IW-1:0]      addr_q;
  logic               rd_vld_q;
  logic               rd_upd_q;
  logic [IW-1:0]      rd_idx_q;

  logic               found_q;
  logic [IW-1:0]      match_idx_q;
  logic [IW-1:0]      match_rank_q;
  logic [VAL_W-1:0]   match_val_q;
  logic [IW-1:0]      lru_idx_q;
  logic [KEY_W-1:0]   lru_key_q;
  logic               free_found_q;
  logic [IW-1:0]      free_idx_q;
  logic [IW-1:0]      tgt_q;
  logic [CW-1:0]      thr_q;
  result_t            res_q;

  logic [KEY_W-1:0]   key_rd;
  logic [VAL_W-1:0]   val_rd;
  logic [IW-1:0]      rank_rd;

  logic               ent_v;
  logic               scan_vld;
  logic               upd_vld;
  logic               key_hit;
  logic               lru_hit;
  logic               free_hit;
  logic               is_put;
  logic [MW-1:0]      cap_m;
  logic [MW-1:0]      cap_eff;
  logic               evict;
  logic [IW-1:0]      tgt_d;
  logic [CW-1:0]      thr_d;
  logic               kv_we;
  logic               ins_new;
  logic               is_tgt;
  logic               rank_we;
  logic [IW-1:0]      rank_wdata;
  result_t            res_d;
  logic [IW-1:0]      addr_d;

  // --- storage ---
  lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (tgt_d),
    .wdata_i (KEY_W'(item_q.key)),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (key_rd)
  );

  lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (tgt_d),
    .wdata_i (VAL_W'(item_q.value)),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (val_rd)
  );

  lkv_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rank_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (rank_rd)
  );

  // --- scan of returned read data ---
  assign ent_v    = valid_q[rd_idx_q];
  assign scan_vld = rd_vld_q & ~rd_upd_q;
  assign upd_vld  = rd_vld_q & rd_upd_q;
  assign key_hit  = scan_vld & ent_v & ~found_q & (key_rd == KEY_W'(item_q.key));
  // ranks of valid entries are a permutation of 0..cnt-1, so LRU has rank cnt-1
  assign lru_hit  = scan_vld & ent_v & (CW'(rank_rd) == (cnt_q - CW'(1)));
  assign free_hit = scan_vld & ~ent_v & ~free_found_q;

  // --- decision ---
  assign is_put = (item_q.func == FUNC_PUT);
  assign cap_m  = MW'(cap_q);

  always_comb begin
    if (cap_m == '0) begin
      cap_eff = MW'(1);
    end else if (cap_m > ENTRIES_M) begin
      cap_eff = ENTRIES_M;
    end else begin
      cap_eff = cap_m;
    end
  end

  assign evict = (MW'(cnt_q) >= cap_eff);

  always_comb begin
    if (found_q) begin
      tgt_d = match_idx_q;
      thr_d = CW'(match_rank_q);
    end else if (evict) begin
      // eviction reuses the slot: same as promoting the LRU entry
      tgt_d = lru_idx_q;
      thr_d = cnt_q - CW'(1);
    end else begin
      tgt_d = free_idx_q;
      thr_d = cnt_q;
    end
  end

  assign kv_we   = cmd_i.decide & is_put;
  assign ins_new = cmd_i.decide & is_put & ~found_q & ~evict;

  always_comb begin
    res_d.hit         = found_q;
    res_d.evicted     = is_put & ~found_q & evict;
    res_d.read_value  = is_put ? '0 : (found_q ? match_val_q : MISS_VALUE);
    res_d.evicted_key = res_d.evicted ? lru_key_q : '0;
  end

  // --- rank update pass ---
  assign is_tgt     = (rd_idx_q == tgt_q);
  assign rank_we    = upd_vld & (is_tgt | (ent_v & (CW'(rank_rd) < thr_q)));
  assign rank_wdata = is_tgt ? '0 : (rank_rd + IW'(1));

  always_comb begin
    if (cmd_i.load | cmd_i.decide) begin
      addr_d = '0;
    end else if (cmd_i.issue) begin
      addr_d = (addr_q == LAST_IDX) ? '0 : (addr_q + IW'(1));
    end else begin
      addr_d = addr_q;
    end
  end

  // --- control registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      cnt_q        <= '0;
      valid_q      <= '0;
      addr_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_upd_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (ins_new) begin
        cnt_q               <= cnt_q + CW'(1);
        valid_q[free_idx_q] <= 1'b1;
      end
      addr_q   <= addr_d;
      rd_vld_q <= cmd_i.issue;
      rd_upd_q <= cmd_i.upd;
      if (cmd_i.load) begin
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (key_hit) begin
          found_q <= 1'b1;
        end
        if (free_hit) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    rd_idx_q <= addr_q;
    if (key_hit) begin
      match_idx_q  <= rd_idx_q;
      match_rank_q <= rank_rd;
      match_val_q  <= val_rd;
    end
    if (lru_hit) begin
      lru_idx_q <= rd_idx_q;
      lru_key_q <= key_rd;
    end
    if (free_hit) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.decide) begin
      tgt_q <= tgt_d;
      thr_q <= thr_d;
      res_q <= res_d;
    end
  end

  assign sts_o.last   = (addr_q == LAST_IDX);
  assign sts_o.found  = found_q;
  assign sts_o.is_put = is_put;
  assign result_o     = res_q;

endmodule

`default_nettype wire

/* rtl/lkv_ctrl.sv */
// Controller of the LRU cache: sequences the scan pass, the decision and
// the rank update pass. Uses lkv_pkg.
`default_nettype none

module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              strobe_o,
  output lkv_pkg::ctl_cmd_t cmd_o,
  input  lkv_pkg::dp_sts_t  sts_i
);

  import lkv_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_SCAN_END = 3'd2;
  localparam logic [2:0] ST_DECIDE   = 3'd3;
  localparam logic [2:0] ST_UPD      = 3'd4;
  localparam logic [2:0] ST_UPD_END  = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        // get miss leaves the ranks alone
        if (!sts_i.found && !sts_i.is_put) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.issue = 1'b1;
        cmd_o.upd   = 1'b1;
        if (sts_i.last) begin
          state_d = ST_UPD_END;
        end
      end
      ST_UPD_END: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

/* rtl/lkv_checker.sv */
// Port-level checker for the LRU cache, bound to the top level.
// Uses lkv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lkv_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input logic             result_strobe_i,
  input lkv_pkg::result_t result_i
);

  import lkv_pkg::*;

  `LKV_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, result_strobe_i, busy_i, "result outside a busy period")
  `LKV_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_i, busy_i && !result_strobe_i, "accepted item did not raise busy")
  `LKV_ASSERT_NXT(a_strobe_end, clk_i, rst_ni, result_strobe_i, !busy_i && !result_strobe_i, "no return to idle after result")
  `LKV_ASSERT_IMP(a_evict_put_miss, clk_i, rst_ni, result_strobe_i && result_i.evicted, !result_i.hit && result_i.read_value == '0, "eviction on a hit or a get")
  `LKV_ASSERT_IMP(a_evkey_zero, clk_i, rst_ni, result_strobe_i && !result_i.evicted, result_i.evicted_key == '0, "evicted key set without eviction")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start),
  .busy_i          (busy),
  .result_strobe_i (result_strobe_o),
  .result_i        (result_o)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for lru_key_value_cache: directed and random get/put
// traffic against an in-bench LRU shadow of the store. Needs lkv_pkg and the RTL.

module tb_top;
  import lkv_pkg::*;

  localparam int unsigned ENTRIES = 16;
  // accept edge to next possible accept on the slow path (hit or put miss)
  localparam int unsigned ACCESS_CYCLES = 2 * ENTRIES + 5;
  localparam int unsigned SETTLE_CYCLES = ACCESS_CYCLES + 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_SIZE = 24;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT connections
  // ---------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  item_t            cmd_item = '0;
  logic             result_strobe_o;
  result_t          result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (cmd_item),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the cache contents. Rank 0 is the most recent valid entry,
  // shadow_count-1 the least recent. Keys/values are only read when valid.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] shadow_key   [ENTRIES];
  logic [VAL_W-1:0] shadow_val   [ENTRIES];
  logic             shadow_valid [ENTRIES];
  int unsigned      shadow_rank  [ENTRIES];
  int unsigned      shadow_count;
  logic [CAP_W-1:0] shadow_cap;

  result_t     cache_replies[$];   // predicted replies, oldest first
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;     // sender gaps on/off

  // Key pool for the random part, refilled per phase so that hits, updates
  // and evictions all turn up often.
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int unsigned      pool_used;

  // One get or put applied to the shadow; returns the reply it must produce.
  function automatic result_t cache_access(input item_t it);
    result_t     r;
    int          match;
    int          slot;
    int unsigned best;
    int unsigned cap;
    int unsigned old_rank;
    r = '0;
    match = -1;
    slot = -1;
    best = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match < 0 && shadow_valid[i] && shadow_key[i] == it.key) match = i;
    end

    if (match >= 0) begin
      r.hit = 1'b1;
      if (it.func == FUNC_PUT) shadow_val[match] = it.value;
      else r.read_value = shadow_val[match];
      // promote: anything more recent than the hit ages by one
      old_rank = shadow_rank[match];
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && i != match && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[match] = 0;
    end else if (it.func == FUNC_GET) begin
      r.read_value = MISS_VALUE;
    end else begin
      // zero behaves as one, anything past the store size as the store size
      cap = shadow_cap;
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      if (shadow_count >= cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > best)) begin
            slot = i;
            best = shadow_rank[i];
          end
        end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = shadow_key[slot];
          shadow_valid[slot] = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_rank[i] > best) shadow_rank[i]--;
          end
          shadow_count--;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i]) shadow_rank[i]++;
        end
        shadow_key[slot] = it.key;
        shadow_val[slot] = it.value;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot] = 0;
        shadow_count++;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side: optional gap with start low, then hold start until the
  // transfer. start is left high afterwards so back-to-back items need no
  // lowering; wait_idle drops it before any pause.
  // ---------------------------------------------------------------------------
  task automatic issue_access(input logic func, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    item_t       it;
    int unsigned gap;
    it.func = func;
    it.key = key;
    it.value = value;
    gap = 0;
    if (idle_en) begin
      // mostly short gaps, now and then one that lands late in a busy period
      if ($urandom_range(7) == 0) gap = $urandom_range(1, ACCESS_CYCLES + 1);
      else while (gap < 8 && $urandom_range(99) < 30) gap++;
    end
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_item <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    cache_replies.insert(cache_replies.size(), cache_access(it));
  endtask

  // Stop sending, wait for every outstanding reply, then let the block settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (cache_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Capacity write; only called once the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_cap = cap;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: every strobe is matched against the oldest prediction.
  // Sampling at the edge sees the values from the cycle that edge ends.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (cache_replies.size() == 0) begin
        $error("unexpected reply: hit=%0b read_value=%h evicted=%0b evicted_key=%h",
               result_o.hit, result_o.read_value, result_o.evicted, result_o.evicted_key);
        mismatches++;
      end else begin
        want = cache_replies.pop_front();
        if (result_o.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, result_o.hit);
          mismatches++;
        end
        if (result_o.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, result_o.read_value);
          mismatches++;
        end
        if (result_o.evicted !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, result_o.evicted);
          mismatches++;
        end
        if (result_o.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, result_o.evicted_key);
          mismatches++;
        end
      end
    end
  end

  // Run limit; far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Get miss on an empty store, puts and gets at the key/value extremes,
  // an update through a put hit, and a near-miss key one bit away.
  task automatic test_basic_ops();
    issue_access(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    issue_access(FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
    issue_access(FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
    issue_access(FUNC_PUT, 32'hffff_ffff, 32'h0000_0000);
    issue_access(FUNC_PUT, 32'h0000_0000, 32'hffff_ffff);
    issue_access(FUNC_GET, 32'h8000_0000, 32'hffff_ffff);
    issue_access(FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
    issue_access(FUNC_PUT, 32'h8000_0000, 32'h1234_5678);
    issue_access(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    issue_access(FUNC_GET, 32'h8000_0001, 32'h0000_0000);
    wait_idle();
  endtask

  // Capacity dropped below the occupied count (one eviction per put miss),
  // the smallest capacity, zero, and values past the store size.
  task automatic test_capacity_limits();
    set_capacity(CAP_W'(2));
    issue_access(FUNC_PUT, 32'h0000_0001, 32'haaaa_5555);
    issue_access(FUNC_PUT, 32'h0000_0002, 32'h5555_aaaa);
    issue_access(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    wait_idle();
    set_capacity(CAP_W'(1));
    issue_access(FUNC_PUT, 32'h0000_0003, 32'h0000_0003);
    issue_access(FUNC_GET, 32'h0000_0003, 32'h0000_0000);
    wait_idle();
    set_capacity(CAP_W'(0));
    issue_access(FUNC_PUT, 32'hdead_beef, 32'h0bad_f00d);
    issue_access(FUNC_GET, 32'h0000_0003, 32'h0000_0000);
    wait_idle();
    set_capacity(CAP_W'(31));
    issue_access(FUNC_PUT, 32'h0000_0004, 32'h0000_0004);
    issue_access(FUNC_GET, 32'hdead_beef, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic fill_key_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(5))
        0: key_pool[i] = 32'h8000_0000;
        1: key_pool[i] = 32'h7fff_ffff;
        // one bit away from another pool key: the compare must use all bits
        2: key_pool[i] = key_pool[$urandom_range(POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(31));
        default: key_pool[i] = $urandom;
      endcase
    end
    pool_used = $urandom_range(2, POOL_SIZE);
  endtask

  // Phases at different capacities; keys mostly from a small pool so the
  // store fills, hits and evicts, the rest fully random.
  task automatic test_random_mix();
    int unsigned      caps[11];
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    caps = '{16, 1, 4, 0, 31, 2, 17, 8, 15, 3, 0};
    caps[10] = $urandom_range(31);
    foreach (caps[p]) begin
      set_capacity(CAP_W'(caps[p]));
      fill_key_pool();
      repeat (110) begin
        if ($urandom_range(99) < 75) key = key_pool[$urandom_range(pool_used - 1)];
        else key = $urandom;
        case ($urandom_range(9))
          0: value = 32'h8000_0000;
          1: value = 32'hffff_ffff;
          2: value = 32'h0000_0000;
          default: value = $urandom;
        endcase
        // occasionally hold off until everything outstanding has come back
        if ($urandom_range(39) == 0) wait_idle();
        issue_access(1'($urandom_range(1)), key, value);
      end
      wait_idle();
    end
  endtask

  // start held high throughout: each item is taken the cycle busy drops.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    set_capacity(CAP_W'(5));
    fill_key_pool();
    repeat (200) begin
      issue_access(1'($urandom_range(1)), key_pool[$urandom_range(pool_used - 1)], $urandom);
    end
    wait_idle();
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_count = 0;
    shadow_cap = CAP_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_ops();
    test_capacity_limits();
    test_random_mix();
    test_back_to_back();

    if (mismatches == 0 && cache_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_datapath.sv
rtl/lkv_ctrl.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
tb/sv/tb_top.sv
